/* sv/msd_pkg.sv */
// Shared types and constants for the message header stream decoder.
// Holds the result kind codes, the front-to-back record and the tdata layout.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package msd_pkg;

  // Result item kinds, carried on m_tuser
  typedef enum logic [2:0] {
    KIND_FIXED  = 3'd0,
    KIND_REMARK = 3'd1,
    KIND_KEY    = 3'd2,
    KIND_VALUE  = 3'd3,
    KIND_DONE   = 3'd4,
    KIND_ERROR  = 3'd5
  } kind_t;

  localparam int unsigned KIND_W  = 3;
  localparam int unsigned TDATA_W = 120;

  // Bit positions of the output tdata fields
  localparam int unsigned POS_CODE   = 0;
  localparam int unsigned POS_LANG   = 16;
  localparam int unsigned POS_VER    = 24;
  localparam int unsigned POS_OPAQUE = 40;
  localparam int unsigned POS_FLAG   = 72;
  localparam int unsigned POS_TEXT   = 104;
  localparam int unsigned POS_SEND   = 112;
  localparam int unsigned POS_EMPTY  = 113;
  localparam int unsigned POS_RPRES  = 114;

  // Everything one input byte causes: an optional content item plus an
  // optional done/error item
  typedef struct packed {
    logic        has_content;
    kind_t       content_kind;
    logic [15:0] code;
    logic [7:0]  lang;
    logic [15:0] version;
    logic [31:0] opaque;
    logic [31:0] flag;
    logic [7:0]  text;
    logic        string_end;
    logic        empty_string;
    logic        has_final;
    logic        final_error;
    logic        remark_present;
  } rec_t;

endpackage

`default_nettype wire

/* sv/message_header_stream_decoder.sv */
// Top level of the message header stream decoder: parse front end, record
// queue and output back end. Depends on msd_pkg, msd_front, msd_queue, msd_back.
//
//   Channel  Dir  Handshake          Payload
//   s_*      in   s_tvalid/s_tready  tdata[7:0] data_byte, tlast last_byte
//   m_*      out  m_tvalid/m_tready  tdata result fields, tuser item_kind,
//                                    tlast run_last
//
// One header byte is accepted per cycle while the queue has room. Its record
// is written to the queue at the accepting edge and later loaded into the
// output register. A byte yields at most one record; the final byte's record
// can hold two items, sent in turn and absorbed by the QUEUE_DEPTH-entry queue.
// s_tready drops only while the queue is full, i.e. under output backpressure.
// rst is synchronous and returns the parser to the first code byte.
`timescale 1ns / 1ps
`default_nettype none

module message_header_stream_decoder import msd_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire logic [7:0]         s_tdata,  // [7:0] data_byte
  input  wire logic               s_tlast,  // last_byte
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  // [15:0] msg_code, [23:16] lang_id, [39:24] proto_version, [71:40] opaque_id,
  // [103:72] flag_word, [111:104] text_byte, [112] string_end,
  // [113] empty_string, [114] remark_present, [119:115] zero
  output logic [TDATA_W-1:0]      m_tdata,
  output logic [KIND_W-1:0]       m_tuser,  // [2:0] item_kind
  output logic                    m_tlast   // run_last
);

  logic q_full;
  logic q_push;
  rec_t q_rec;
  logic q_pop;
  logic q_valid;
  rec_t q_head;

  msd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_rec    (q_rec)
  );

  msd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_rec (q_rec),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  msd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // A record is never pushed into a full queue
  assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("record pushed into full queue");

  // The final byte of a header always leaves a record behind
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tlast) |-> q_push)
    else $error("final byte produced no record");

  // Done and error items close the run of their byte
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == KIND_DONE || m_tuser == KIND_ERROR)) |-> m_tlast)
    else $error("done or error item without run_last");

  // Fixed-field items carry no text or flag bits
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == KIND_FIXED) |-> (m_tdata[TDATA_W-1:POS_TEXT] == '0))
    else $error("fixed-field item with text bits set");

endmodule

`default_nettype wire

/* sv/msd_front.sv */
// Front end of the header decoder: accepts header bytes and runs the parse.
// Produces one record per byte that causes results. Depends on msd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module msd_front import msd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] data_byte
  input  wire logic       s_tlast,   // last_byte
  input  wire logic       q_full,
  output logic            q_push,
  output rec_t            q_rec
);

  typedef enum logic [12:0] {
    PH_CODE     = 13'b0000000000001,
    PH_LANG     = 13'b0000000000010,
    PH_VER      = 13'b0000000000100,
    PH_OPAQ     = 13'b0000000001000,
    PH_FLAG     = 13'b0000000010000,
    PH_REMLEN   = 13'b0000000100000,
    PH_REMARK   = 13'b0000001000000,
    PH_EXTLEN   = 13'b0000010000000,
    PH_KEYLEN   = 13'b0000100000000,
    PH_KEY      = 13'b0001000000000,
    PH_VALLEN   = 13'b0010000000000,
    PH_VAL      = 13'b0100000000000,
    PH_COMPLETE = 13'b1000000000000
  } phase_t;

  phase_t      phase, phase_next;
  logic [2:0]  byte_index, byte_index_next;
  logic [31:0] assemble, assemble_next;
  logic [15:0] code, code_next;
  logic [7:0]  lang, lang_next;
  logic [15:0] version, version_next;
  logic [31:0] opaque, opaque_next;
  logic [31:0] str_rem, str_rem_next;
  logic [31:0] ext_rem, ext_rem_next;
  logic        remark_seen, remark_seen_next;

  logic        accept;
  logic [31:0] asm_shift;
  logic [2:0]  idx_inc;
  logic [2:0]  need;
  logic        field_done;
  logic [31:0] ext_dec;
  logic        str_one;
  rec_t        rec;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  // Byte gathering helpers, shared by the multi-byte length and field phases
  assign asm_shift  = {assemble[23:0], s_tdata};
  assign idx_inc    = byte_index + 3'd1;
  assign need       = (phase == PH_CODE || phase == PH_VER || phase == PH_KEYLEN) ? 3'd2 : 3'd4;
  assign field_done = (idx_inc >= need);
  assign ext_dec    = (ext_rem == 32'd0) ? ext_rem : ext_rem - 32'd1;
  assign str_one    = (str_rem == 32'd1);

  // Parse step for one accepted byte
  always_comb begin
    phase_next       = phase;
    byte_index_next  = byte_index;
    assemble_next    = assemble;
    code_next        = code;
    lang_next        = lang;
    version_next     = version;
    opaque_next      = opaque;
    str_rem_next     = str_rem;
    ext_rem_next     = ext_rem;
    remark_seen_next = remark_seen;
    rec              = '0;
    rec.content_kind = KIND_FIXED;

    if (accept) begin
      case (phase)
        PH_CODE, PH_VER, PH_OPAQ, PH_FLAG, PH_REMLEN, PH_EXTLEN, PH_KEYLEN, PH_VALLEN: begin
          assemble_next   = asm_shift;
          byte_index_next = field_done ? 3'd0 : idx_inc;
        end
        default: begin
        end
      endcase

      case (phase)
        PH_KEYLEN, PH_KEY, PH_VALLEN, PH_VAL: ext_rem_next = ext_dec;
        default: begin
        end
      endcase

      case (phase)
        PH_CODE: begin
          if (field_done) begin
            code_next  = asm_shift[15:0];
            phase_next = PH_LANG;
          end
        end
        PH_LANG: begin
          lang_next  = s_tdata;
          phase_next = PH_VER;
        end
        PH_VER: begin
          if (field_done) begin
            version_next = asm_shift[15:0];
            phase_next   = PH_OPAQ;
          end
        end
        PH_OPAQ: begin
          if (field_done) begin
            opaque_next = asm_shift;
            phase_next  = PH_FLAG;
          end
        end
        PH_FLAG: begin
          if (field_done) begin
            rec.has_content  = 1'b1;
            rec.content_kind = KIND_FIXED;
            rec.code         = code;
            rec.lang         = lang;
            rec.version      = version;
            rec.opaque       = opaque;
            rec.flag         = asm_shift;
            phase_next       = PH_REMLEN;
          end
        end
        PH_REMLEN: begin
          if (field_done) begin
            str_rem_next     = asm_shift;
            remark_seen_next = (asm_shift != 32'd0);
            phase_next       = (asm_shift != 32'd0) ? PH_REMARK : PH_EXTLEN;
          end
        end
        PH_REMARK: begin
          rec.has_content  = 1'b1;
          rec.content_kind = KIND_REMARK;
          rec.text         = s_tdata;
          rec.string_end   = str_one;
          str_rem_next     = str_rem - 32'd1;
          if (str_one) phase_next = PH_EXTLEN;
        end
        PH_EXTLEN: begin
          if (field_done) begin
            ext_rem_next = asm_shift;
            phase_next   = (asm_shift == 32'd0) ? PH_COMPLETE : PH_KEYLEN;
          end
        end
        PH_KEYLEN: begin
          if (field_done) begin
            str_rem_next = {16'd0, asm_shift[15:0]};
            if (asm_shift[15:0] == 16'd0) begin
              // empty key stands as one item of its own
              rec.has_content  = 1'b1;
              rec.content_kind = KIND_KEY;
              rec.string_end   = 1'b1;
              rec.empty_string = 1'b1;
              phase_next       = PH_VALLEN;
            end else begin
              phase_next = PH_KEY;
            end
          end
        end
        PH_KEY: begin
          rec.has_content  = 1'b1;
          rec.content_kind = KIND_KEY;
          rec.text         = s_tdata;
          rec.string_end   = str_one;
          str_rem_next     = str_rem - 32'd1;
          if (str_one) phase_next = PH_VALLEN;
        end
        PH_VALLEN: begin
          if (field_done) begin
            str_rem_next = asm_shift;
            if (asm_shift == 32'd0) begin
              rec.has_content  = 1'b1;
              rec.content_kind = KIND_VALUE;
              rec.string_end   = 1'b1;
              rec.empty_string = 1'b1;
              phase_next       = (ext_dec == 32'd0) ? PH_COMPLETE : PH_KEYLEN;
            end else begin
              phase_next = PH_VAL;
            end
          end
        end
        PH_VAL: begin
          rec.has_content  = 1'b1;
          rec.content_kind = KIND_VALUE;
          rec.text         = s_tdata;
          rec.string_end   = str_one;
          str_rem_next     = str_rem - 32'd1;
          if (str_one) phase_next = (ext_dec == 32'd0) ? PH_COMPLETE : PH_KEYLEN;
        end
        default: begin
        end
      endcase

      // Final byte: verdict, then back to the start of a header
      if (s_tlast) begin
        rec.has_final      = 1'b1;
        rec.final_error    = (phase_next != PH_COMPLETE);
        rec.remark_present = (phase_next == PH_COMPLETE) && remark_seen_next;
        phase_next         = PH_CODE;
        byte_index_next    = 3'd0;
        remark_seen_next   = 1'b0;
      end
    end
  end

  assign q_push = accept && (rec.has_content || rec.has_final);
  assign q_rec  = rec;

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_CODE;
      byte_index  <= 3'd0;
      remark_seen <= 1'b0;
    end else begin
      phase       <= phase_next;
      byte_index  <= byte_index_next;
      remark_seen <= remark_seen_next;
    end
  end

  // Field and length registers, always written before they are used
  always_ff @(posedge clk) begin
    assemble <= assemble_next;
    code     <= code_next;
    lang     <= lang_next;
    version  <= version_next;
    opaque   <= opaque_next;
    str_rem  <= str_rem_next;
    ext_rem  <= ext_rem_next;
  end

endmodule

`default_nettype wire

/* sv/msd_queue.sv */
// Short record queue between the parse front end and the output back end.
// Circular buffer with a fill count. Depends on msd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module msd_queue import msd_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  rec_t      push_rec,
  output logic      full,
  input  wire logic pop,
  output logic      valid,
  output rec_t      head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  rec_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == FULL_CNT);
  assign valid   = (count != '0);
  assign head    = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_rec;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      if (do_pop)  rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

/* sv/msd_back.sv */
// Back end of the header decoder: splits queued records into result items
// and holds them in the output register. Depends on msd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module msd_back import msd_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_valid,
  input  rec_t                   q_head,
  output logic                   q_pop,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [TDATA_W-1:0]     m_tdata,
  output logic [KIND_W-1:0]      m_tuser,
  output logic                   m_tlast
);

  logic               second;     // content of head record already sent
  logic               load;
  logic               take_content;
  logic [TDATA_W-1:0] data_next;
  logic [KIND_W-1:0]  kind_next;
  logic               last_next;

  assign load         = !m_tvalid || m_tready;
  assign take_content = !second && q_head.has_content;
  assign q_pop        = load && q_valid && !(take_content && q_head.has_final);

  // Build the next item from the queue head
  always_comb begin
    data_next = '0;
    if (take_content) begin
      kind_next = q_head.content_kind;
      last_next = !q_head.has_final;
      if (q_head.content_kind == KIND_FIXED) begin
        data_next[POS_CODE +: 16]   = q_head.code;
        data_next[POS_LANG +: 8]    = q_head.lang;
        data_next[POS_VER +: 16]    = q_head.version;
        data_next[POS_OPAQUE +: 32] = q_head.opaque;
        data_next[POS_FLAG +: 32]   = q_head.flag;
      end else begin
        data_next[POS_TEXT +: 8]  = q_head.text;
        data_next[POS_SEND]       = q_head.string_end;
        data_next[POS_EMPTY]      = q_head.empty_string;
      end
    end else begin
      kind_next            = q_head.final_error ? KIND_ERROR : KIND_DONE;
      last_next            = 1'b1;
      data_next[POS_RPRES] = q_head.remark_present;
    end
  end

  // Output register and record split control
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      second   <= 1'b0;
    end else if (load) begin
      m_tvalid <= q_valid;
      if (q_valid) second <= take_content && q_head.has_final;
    end
  end

  always_ff @(posedge clk) begin
    if (load && q_valid) begin
      m_tdata <= data_next;
      m_tuser <= kind_next;
      m_tlast <= last_next;
    end
  end

endmodule

`default_nettype wire

/* sim/message_header_stream_decoder_test.sv */
// Self-checking testbench for message_header_stream_decoder: streams serialized
// headers into the decoder and checks every result item against its own decoder.
// Depends on msd_pkg and the decoder RTL.
`timescale 1ns / 1ps

module message_header_stream_decoder_test;
  import msd_pkg::*;

  localparam int unsigned HALF_PERIOD     = 6;
  localparam int unsigned RESET_CYCLES    = 5;
  localparam int unsigned TAIL_CYCLES     = 16;   // pipeline plus output queue
  localparam int unsigned STALL_LIMIT     = 2000;
  localparam int unsigned HOLD_CYCLES     = 120;
  localparam int unsigned BYTES_PER_PHASE = 630;

  // Parser position inside one header
  typedef enum logic [3:0] {
    ST_CODE, ST_LANG, ST_VER, ST_OPAQUE, ST_FLAG, ST_REMLEN, ST_REMARK,
    ST_EXTLEN, ST_KEYLEN, ST_KEY, ST_VALLEN, ST_VAL, ST_COMPLETE
  } parse_state_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] code;
    logic [7:0]  lang;
    logic [15:0] version;
    logic [31:0] opaque;
    logic [31:0] flag;
    logic [7:0]  text;
    logic        string_end;
    logic        empty_string;
    logic        remark_present;
    logic        run_last;
  } header_item_t;

  // Tracks decoder state per accepted byte and holds the items still owed
  class header_scoreboard;
    parse_state_t state;
    logic [2:0]   idx;
    logic [31:0]  acc;
    logic [15:0]  code_r;
    logic [7:0]   lang_r;
    logic [15:0]  ver_r;
    logic [31:0]  opaque_r;
    logic [31:0]  str_left;
    logic [32:0]  ext_left;
    logic         remark_seen;
    header_item_t owed_items[$];
    int unsigned  fails;

    function new();
      fails = 0;
      clear();
    endfunction

    function void clear();
      state       = ST_CODE;
      idx         = '0;
      acc         = '0;
      code_r      = '0;
      lang_r      = '0;
      ver_r       = '0;
      opaque_r    = '0;
      str_left    = '0;
      ext_left    = '0;
      remark_seen = 1'b0;
    endfunction

    // Shift one byte into the big-endian accumulator; true once the field is whole
    function bit gather(logic [7:0] b, int unsigned need);
      acc = {acc[23:0], b};
      idx = idx + 3'd1;
      if (idx >= need) begin
        idx = '0;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void eat_ext();
      if (ext_left != 0) ext_left--;
    endfunction

    function void end_entry();
      state = (ext_left == 0) ? ST_COMPLETE : ST_KEYLEN;
    endfunction

    function header_item_t text_item(kind_t k, logic [7:0] b, logic last_one, logic empty);
      header_item_t it;
      it = '0;
      it.kind = k;
      it.text = b;
      it.string_end = last_one;
      it.empty_string = empty;
      return it;
    endfunction

    // Accepted input transaction: work out the result items it causes
    function void note_byte(logic [7:0] b, logic is_last);
      header_item_t produced[$];
      header_item_t it;
      case (state)
        ST_CODE: if (gather(b, 2)) begin
          code_r = acc[15:0];
          state = ST_LANG;
        end
        ST_LANG: begin
          lang_r = b;
          state = ST_VER;
        end
        ST_VER: if (gather(b, 2)) begin
          ver_r = acc[15:0];
          state = ST_OPAQUE;
        end
        ST_OPAQUE: if (gather(b, 4)) begin
          opaque_r = acc;
          state = ST_FLAG;
        end
        ST_FLAG: if (gather(b, 4)) begin
          it = '0;
          it.kind = KIND_FIXED;
          it.code = code_r;
          it.lang = lang_r;
          it.version = ver_r;
          it.opaque = opaque_r;
          it.flag = acc;
          produced = {produced, it};
          state = ST_REMLEN;
        end
        ST_REMLEN: if (gather(b, 4)) begin
          str_left = acc;
          remark_seen = (acc != 0);
          state = (acc != 0) ? ST_REMARK : ST_EXTLEN;
        end
        ST_REMARK: begin
          produced = {produced, text_item(KIND_REMARK, b, str_left == 1, 1'b0)};
          str_left--;
          if (str_left == 0) state = ST_EXTLEN;
        end
        ST_EXTLEN: if (gather(b, 4)) begin
          ext_left = {1'b0, acc};
          state = (acc == 0) ? ST_COMPLETE : ST_KEYLEN;
        end
        ST_KEYLEN: begin
          eat_ext();
          if (gather(b, 2)) begin
            str_left = {16'h0, acc[15:0]};
            if (str_left == 0) begin
              produced = {produced, text_item(KIND_KEY, 8'h00, 1'b1, 1'b1)};
              state = ST_VALLEN;
            end else begin
              state = ST_KEY;
            end
          end
        end
        ST_KEY: begin
          eat_ext();
          produced = {produced, text_item(KIND_KEY, b, str_left == 1, 1'b0)};
          str_left--;
          if (str_left == 0) state = ST_VALLEN;
        end
        ST_VALLEN: begin
          eat_ext();
          if (gather(b, 4)) begin
            str_left = acc;
            if (str_left == 0) begin
              produced = {produced, text_item(KIND_VALUE, 8'h00, 1'b1, 1'b1)};
              end_entry();
            end else begin
              state = ST_VAL;
            end
          end
        end
        ST_VAL: begin
          eat_ext();
          produced = {produced, text_item(KIND_VALUE, b, str_left == 1, 1'b0)};
          str_left--;
          if (str_left == 0) end_entry();
        end
        default: ;
      endcase

      // Final byte closes the header with done or error and restarts parsing
      if (is_last) begin
        it = '0;
        if (state == ST_COMPLETE) begin
          it.kind = KIND_DONE;
          it.remark_present = remark_seen;
        end else begin
          it.kind = KIND_ERROR;
        end
        produced = {produced, it};
        clear();
      end

      if (produced.size() > 0) produced[produced.size() - 1].run_last = 1'b1;
      owed_items = {owed_items, produced};
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
        fails++;
      end
    endfunction

    // Accepted output transaction: compare with the oldest owed item
    function void check_result(logic [TDATA_W-1:0] data, logic [KIND_W-1:0] kind,
                               logic last);
      header_item_t want;
      if (owed_items.size() == 0) begin
        $error("unexpected result: item_kind %0d, tdata 0x%0h", kind, data);
        fails++;
        return;
      end
      want = owed_items.pop_front();
      check_field("item_kind", want.kind, kind);
      check_field("msg_code", want.code, data[POS_CODE +: 16]);
      check_field("lang_id", want.lang, data[POS_LANG +: 8]);
      check_field("proto_version", want.version, data[POS_VER +: 16]);
      check_field("opaque_id", want.opaque, data[POS_OPAQUE +: 32]);
      check_field("flag_word", want.flag, data[POS_FLAG +: 32]);
      check_field("text_byte", want.text, data[POS_TEXT +: 8]);
      check_field("string_end", want.string_end, data[POS_SEND]);
      check_field("empty_string", want.empty_string, data[POS_EMPTY]);
      check_field("remark_present", want.remark_present, data[POS_RPRES]);
      check_field("tdata_pad", 32'h0, data[TDATA_W-1:POS_RPRES+1]);
      check_field("run_last", want.run_last, last);
    endfunction

    function bit is_idle();
      return owed_items.size() == 0;
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [7:0]         s_tdata = 8'h00;
  logic               s_tlast = 1'b0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [TDATA_W-1:0] m_tdata;
  logic [KIND_W-1:0]  m_tuser;
  logic               m_tlast;

  int unsigned        tx_idle_pct = 0;
  int unsigned        rx_idle_pct = 0;
  bit                 hold_wanted = 1'b0;
  bit                 hold_taken = 1'b0;
  int unsigned        hold_left = 0;
  int unsigned        quiet_cycles = 0;
  logic [7:0]         hdr_bytes[$];
  header_scoreboard   sb = new();

  message_header_stream_decoder dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #(HALF_PERIOD) clk = ~clk;
  end

  // Receiver: random backpressure, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_wanted && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Monitor both channels at the clock edge
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_byte(s_tdata, s_tlast);
      if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser, m_tlast);
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] value, input logic is_last);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    s_tlast  <= is_last;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_header();
    foreach (hdr_bytes[i]) send_byte(hdr_bytes[i], i == hdr_bytes.size() - 1);
  endtask

  // Stop offering, wait for every owed item, then let the pipeline settle
  task automatic wait_quiet();
    s_tvalid <= 1'b0;
    // let the monitor note the last accepted byte first
    @(posedge clk);
    while (!sb.is_idle()) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  function automatic void push_be(logic [31:0] value, int unsigned nbytes);
    for (int i = nbytes - 1; i >= 0; i--) hdr_bytes = {hdr_bytes, value[8*i +: 8]};
  endfunction

  function automatic void push_random(int unsigned n);
    repeat (n) hdr_bytes = {hdr_bytes, 8'($urandom_range(255))};
  endfunction

  function automatic logic [31:0] pick_word();
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel == 0) return 32'h0;
    if (sel == 1) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  // One header: mostly well formed, some with a short or long extension
  // length, some broken (huge lengths, cut short) and a little raw noise
  function automatic void make_header();
    int unsigned style, flaw, n_entries, remark_len, key_len, val_len, ext_at, cut;
    logic [31:0] ext_len;
    hdr_bytes.delete();
    style = $urandom_range(99);
    if (style < 5) begin
      push_random($urandom_range(1, 30));
      return;
    end
    flaw = (style >= 90) ? $urandom_range(1, 4) : 0;
    push_be(pick_word(), 2);
    push_be(pick_word(), 1);
    push_be(pick_word(), 2);
    push_be(pick_word(), 4);
    push_be(pick_word(), 4);
    remark_len = ($urandom_range(9) < 3) ? 0 : $urandom_range(1, 6);
    push_be((flaw == 1) ? ($urandom | 32'h8000_0000) : remark_len, 4);
    push_random(remark_len);
    // extension length is patched in once the entries are laid out
    ext_at = hdr_bytes.size();
    push_be(32'h0, 4);
    n_entries = $urandom_range(0, 3);
    for (int e = 0; e < n_entries; e++) begin
      key_len = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 4);
      val_len = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 5);
      push_be((flaw == 2 && e == 0) ? (key_len | 32'hFF00) : key_len, 2);
      push_random(key_len);
      push_be(val_len, 4);
      push_random(val_len);
    end
    ext_len = hdr_bytes.size() - ext_at - 4;
    if (style >= 75 && style < 85 && ext_len > 1) ext_len = $urandom_range(1, ext_len - 1);
    else if (style >= 85 && style < 90) ext_len += $urandom_range(1, 10);
    else if (flaw == 3) ext_len = $urandom | 32'h8000_0000;
    for (int i = 0; i < 4; i++) hdr_bytes[ext_at + i] = ext_len[8*(3-i) +: 8];
    if (flaw == 4) begin
      cut = $urandom_range(1, hdr_bytes.size() - 1);
      while (hdr_bytes.size() > cut) void'(hdr_bytes.pop_back());
    end else if (style < 90 && $urandom_range(4) == 0) begin
      push_random($urandom_range(1, 5));
    end
  endfunction

  task automatic run_phase(int unsigned tx_pct, int unsigned rx_pct);
    int unsigned sent;
    sent = 0;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    while (sent < BYTES_PER_PHASE) begin
      make_header();
      sent += hdr_bytes.size();
      send_header();
    end
    wait_quiet();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    tx_idle_pct = 6;
    rx_idle_pct = 55;

    // Lone final byte: header cut inside the code field
    hdr_bytes.delete();
    hdr_bytes = {hdr_bytes, 8'hA5};
    send_header();

    // Minimal complete header, fixed fields all ones, no remark, empty extension
    hdr_bytes.delete();
    push_be(32'hFFFF, 2);
    push_be(32'hFF, 1);
    push_be(32'hFFFF, 2);
    push_be(32'hFFFF_FFFF, 4);
    push_be(32'hFFFF_FFFF, 4);
    push_be(32'h0, 4);
    push_be(32'h0, 4);
    send_header();

    run_phase(6, 55);
    run_phase(55, 6);
    // receiver stalls long enough to fill the decoder while bytes keep coming
    hold_wanted = 1'b1;
    run_phase(0, 0);

    if (sb.fails == 0 && sb.is_idle()) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

/* filelist.f */
sv/msd_pkg.sv
sv/msd_front.sv
sv/msd_queue.sv
sv/msd_back.sv
sv/message_header_stream_decoder.sv
sim/message_header_stream_decoder_test.sv
